// ===== src/assert_macros.svh =====
// Assertion macros included by the reflectance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/fdr_pkg.sv =====
// Package with widths and constants of the Fresnel reflectance block.
`default_nettype none
package fdr_pkg;
  localparam int COS_W = 16;
  localparam int ETA_W = 16;
  localparam int REFL_W = 16;
  localparam int FRAC_BITS_DEF = 15;
  localparam logic signed [COS_W-1:0] ONE_Q14 = 16'sd16384;
endpackage
`default_nettype wire

// ===== src/fdr_in_if.sv =====
// Input channel interface: incident cosine and the two refractive indices.
`default_nettype none
interface fdr_in_if import fdr_pkg::*; ();
  logic valid;
  logic ready;
  logic signed [COS_W-1:0] cos_incident;
  logic [ETA_W-1:0] eta_incident;
  logic [ETA_W-1:0] eta_transmitted;
  modport source(output valid, cos_incident, eta_incident, eta_transmitted, input ready);
  modport sink(input valid, cos_incident, eta_incident, eta_transmitted, output ready);
endinterface
`default_nettype wire

// ===== src/fdr_out_if.sv =====
// Output channel interface: reflectance and total reflection flag.
`default_nettype none
interface fdr_out_if import fdr_pkg::*; ();
  logic valid;
  logic ready;
  logic [REFL_W-1:0] reflectance;
  logic total_reflection;
  modport source(output valid, reflectance, total_reflection, input ready);
  modport sink(input valid, reflectance, total_reflection, output ready);
endinterface
`default_nettype wire

// ===== src/fresnel_dielectric_reflectance.sv =====
// Pipelined unpolarized Fresnel reflectance of a dielectric interface.
// The req channel carries one transaction per shading sample: a Q2.14 incident
// cosine and two Q4.12 refractive indices. The rsp channel returns the Q1.15
// reflectance and a flag for total internal reflection, one transaction per
// request, in request order.
// The pipeline is 84 register stages deep. A new request is taken in every
// cycle unless a result waits with rsp.ready low; the depth is set
// by the bit-per-stage dividers (29 stages for the squared transmitted cosine,
// 32 for the two amplitude ratios) and the 15-stage square root.
// Reset clears all valid bits; the pipeline then holds no transactions.
// When the receiver holds rsp.ready low while a result waits, the whole
// pipeline halts and req.ready drops; nothing is lost or repeated.
`default_nettype none
`include "assert_macros.svh"
module fresnel_dielectric_reflectance import fdr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  fdr_in_if.sink req,
  fdr_out_if.source rsp
);
  localparam logic [64:0] ONE_RES = 65'd1 << FRAC_BITS;
  localparam logic [64:0] HALF_RES = 65'd1 << (62 - FRAC_BITS);
  localparam int SHIFT = 63 - FRAC_BITS;

  logic en;
  assign en = !rsp.valid || rsp.ready;
  assign req.ready = en;

  // Stage 1: clamp and fold the cosine.
  logic signed [COS_W-1:0] cl;
  logic signed [COS_W:0] cabs;
  logic s1_v;
  logic [14:0] s1_c;
  logic [ETA_W-1:0] s1_ei, s1_et;
  always_comb begin
    if (req.cos_incident > ONE_Q14) begin
      cl = ONE_Q14;
    end else if (req.cos_incident < -ONE_Q14) begin
      cl = -ONE_Q14;
    end else begin
      cl = req.cos_incident;
    end
    cabs = cl[COS_W-1] ? -(17'(cl)) : 17'(cl);
  end
  always_ff @(posedge clk) begin
    if (rst) s1_v <= 1'b0;
    else if (en) s1_v <= req.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_c <= cabs[14:0];
      s1_ei <= cl[COS_W-1] ? req.eta_transmitted : req.eta_incident;
      s1_et <= cl[COS_W-1] ? req.eta_incident : req.eta_transmitted;
    end
  end

  // Stage 2: squares.
  logic s2_v;
  logic [28:0] s2_c2;
  logic [31:0] s2_ei2, s2_et2;
  logic [14:0] s2_c;
  logic [ETA_W-1:0] s2_ei, s2_et;
  always_ff @(posedge clk) begin
    if (rst) s2_v <= 1'b0;
    else if (en) s2_v <= s1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s2_c2 <= 29'(s1_c) * 29'(s1_c);
      s2_ei2 <= 32'(s1_ei) * 32'(s1_ei);
      s2_et2 <= 32'(s1_et) * 32'(s1_et);
      s2_c <= s1_c;
      s2_ei <= s1_ei;
      s2_et <= s1_et;
    end
  end

  // Stage 3: etaI^2 * sinI^2.
  logic [28:0] sin2;
  logic s3_v;
  logic [60:0] s3_lhs;
  logic [31:0] s3_et2;
  logic [14:0] s3_c;
  logic [ETA_W-1:0] s3_ei, s3_et;
  assign sin2 = (29'd1 << 28) - s2_c2;
  always_ff @(posedge clk) begin
    if (rst) s3_v <= 1'b0;
    else if (en) s3_v <= s2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_lhs <= 61'(s2_ei2) * 61'(sin2);
      s3_et2 <= s2_et2;
      s3_c <= s2_c;
      s3_ei <= s2_ei;
      s3_et <= s2_et;
    end
  end

  // Stage 4 and the cosT^2 divider.
  logic [59:0] rhs;
  logic d1_v [0:29];
  logic d1_tir [0:29];
  logic [59:0] d1_rem [0:29];
  logic [28:0] d1_q [0:29];
  logic [31:0] d1_d [0:29];
  logic [14:0] d1_c [0:29];
  logic [ETA_W-1:0] d1_ei [0:29];
  logic [ETA_W-1:0] d1_et [0:29];
  assign rhs = {s3_et2, 28'd0};
  always_ff @(posedge clk) begin
    if (rst) d1_v[0] <= 1'b0;
    else if (en) d1_v[0] <= s3_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d1_tir[0] <= s3_lhs >= 61'(rhs);
      d1_rem[0] <= rhs - s3_lhs[59:0];
      d1_q[0] <= '0;
      d1_d[0] <= s3_et2;
      d1_c[0] <= s3_c;
      d1_ei[0] <= s3_ei;
      d1_et[0] <= s3_et;
    end
  end
  for (genvar i = 0; i < 29; i++) begin : g_div1
    localparam int K = 28 - i;
    logic [59:0] trial;
    logic ge;
    logic [28:0] qn;
    always_comb begin
      trial = 60'(d1_d[i]) << K;
      ge = d1_rem[i] >= trial;
      qn = d1_q[i];
      qn[K] = ge;
    end
    always_ff @(posedge clk) begin
      if (rst) d1_v[i+1] <= 1'b0;
      else if (en) d1_v[i+1] <= d1_v[i];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d1_rem[i+1] <= ge ? d1_rem[i] - trial : d1_rem[i];
        d1_q[i+1] <= qn;
        d1_tir[i+1] <= d1_tir[i];
        d1_d[i+1] <= d1_d[i];
        d1_c[i+1] <= d1_c[i];
        d1_ei[i+1] <= d1_ei[i];
        d1_et[i+1] <= d1_et[i];
      end
    end
  end

  // Square root of cosT^2, one result bit per stage.
  logic sq_v [1:15];
  logic sq_tir [1:15];
  logic [28:0] sq_rem [1:15];
  logic [14:0] sq_r [1:15];
  logic [14:0] sq_c [1:15];
  logic [ETA_W-1:0] sq_ei [1:15];
  logic [ETA_W-1:0] sq_et [1:15];
  for (genvar j = 0; j < 15; j++) begin : g_sqrt
    localparam int K = 14 - j;
    logic v_in, tir_in;
    logic [28:0] rem_in;
    logic [14:0] r_in, rn;
    logic [14:0] c_in;
    logic [ETA_W-1:0] ei_in, et_in;
    logic [30:0] trial;
    logic ge;
    if (j == 0) begin : g_first
      assign v_in = d1_v[29];
      assign tir_in = d1_tir[29];
      assign rem_in = d1_q[29];
      assign r_in = '0;
      assign c_in = d1_c[29];
      assign ei_in = d1_ei[29];
      assign et_in = d1_et[29];
    end else begin : g_rest
      assign v_in = sq_v[j];
      assign tir_in = sq_tir[j];
      assign rem_in = sq_rem[j];
      assign r_in = sq_r[j];
      assign c_in = sq_c[j];
      assign ei_in = sq_ei[j];
      assign et_in = sq_et[j];
    end
    always_comb begin
      trial = (31'(r_in) << (K + 1)) + (31'd1 << (2 * K));
      ge = 31'(rem_in) >= trial;
      rn = r_in;
      rn[K] = ge;
    end
    always_ff @(posedge clk) begin
      if (rst) sq_v[j+1] <= 1'b0;
      else if (en) sq_v[j+1] <= v_in;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rem[j+1] <= ge ? 29'(31'(rem_in) - trial) : rem_in;
        sq_r[j+1] <= rn;
        sq_tir[j+1] <= tir_in;
        sq_c[j+1] <= c_in;
        sq_ei[j+1] <= ei_in;
        sq_et[j+1] <= et_in;
      end
    end
  end

  // Products for the two amplitude ratios.
  logic m_v, m_tir;
  logic [30:0] m_x [0:1];
  logic [30:0] m_y [0:1];
  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (en) m_v <= sq_v[15];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tir <= sq_tir[15];
      m_x[0] <= 31'(sq_et[15]) * 31'(sq_c[15]);
      m_y[0] <= 31'(sq_ei[15]) * 31'(sq_r[15]);
      m_x[1] <= 31'(sq_ei[15]) * 31'(sq_c[15]);
      m_y[1] <= 31'(sq_et[15]) * 31'(sq_r[15]);
    end
  end

  // Ratio dividers, two lanes, one quotient bit per stage.
  logic d2_v [0:32];
  logic d2_tir [0:32];
  logic [62:0] d2_rem [0:32][0:1];
  logic [31:0] d2_den [0:32][0:1];
  logic [31:0] d2_q [0:32][0:1];
  logic d2_z [0:32][0:1];
  always_ff @(posedge clk) begin
    if (rst) d2_v[0] <= 1'b0;
    else if (en) d2_v[0] <= m_v;
  end
  always_ff @(posedge clk) begin
    if (en) d2_tir[0] <= m_tir;
  end
  for (genvar l = 0; l < 2; l++) begin : g_lane_in
    logic [31:0] sum;
    logic [30:0] diff;
    always_comb begin
      sum = 32'(m_x[l]) + 32'(m_y[l]);
      diff = (m_x[l] >= m_y[l]) ? m_x[l] - m_y[l] : m_y[l] - m_x[l];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d2_rem[0][l] <= {1'b0, diff, 31'd0};
        d2_den[0][l] <= sum;
        d2_q[0][l] <= '0;
        d2_z[0][l] <= sum == 32'd0;
      end
    end
  end
  for (genvar i = 0; i < 32; i++) begin : g_div2
    localparam int K = 31 - i;
    always_ff @(posedge clk) begin
      if (rst) d2_v[i+1] <= 1'b0;
      else if (en) d2_v[i+1] <= d2_v[i];
    end
    always_ff @(posedge clk) begin
      if (en) d2_tir[i+1] <= d2_tir[i];
    end
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [62:0] trial;
      logic ge;
      logic [31:0] qn;
      always_comb begin
        trial = 63'(d2_den[i][l]) << K;
        ge = d2_rem[i][l] >= trial;
        qn = d2_q[i][l];
        qn[K] = ge;
      end
      always_ff @(posedge clk) begin
        if (en) begin
          d2_rem[i+1][l] <= ge ? d2_rem[i][l] - trial : d2_rem[i][l];
          d2_den[i+1][l] <= d2_den[i][l];
          d2_q[i+1][l] <= qn;
          d2_z[i+1][l] <= d2_z[i][l];
        end
      end
    end
  end

  // Squares of the ratios.
  logic p_v, p_tir;
  logic [63:0] p_sq [0:1];
  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (en) p_v <= d2_v[32];
  end
  for (genvar l = 0; l < 2; l++) begin : g_square
    logic [31:0] qa;
    assign qa = d2_z[32][l] ? 32'h8000_0000 : d2_q[32][l];
    always_ff @(posedge clk) begin
      if (en) p_sq[l] <= 64'(qa) * 64'(qa);
    end
  end
  always_ff @(posedge clk) begin
    if (en) p_tir <= d2_tir[32];
  end

  // Rounding, saturation, the total reflection override and the output register.
  logic [64:0] acc, res;
  logic [REFL_W-1:0] refl;
  always_comb begin
    acc = 65'(p_sq[0]) + 65'(p_sq[1]) + HALF_RES;
    res = acc >> SHIFT;
    if (res > ONE_RES) res = ONE_RES;
    refl = p_tir ? ONE_RES[REFL_W-1:0] : res[REFL_W-1:0];
  end
  always_ff @(posedge clk) begin
    if (rst) rsp.valid <= 1'b0;
    else if (en) rsp.valid <= p_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.reflectance <= refl;
      rsp.total_reflection <= p_tir;
    end
  end

  `ASSERT_SAME(a_tir_full, clk, rst, rsp.valid && rsp.total_reflection, rsp.reflectance == ONE_RES[REFL_W-1:0], "total reflection must report full reflectance")
  `ASSERT_SAME(a_stall_halts, clk, rst, rsp.valid && !rsp.ready, !req.ready, "request taken while the result is stalled")
  `ASSERT_NEXT(a_enter, clk, rst, req.valid && req.ready, s1_v, "accepted transaction did not enter the pipeline")
endmodule
`default_nettype wire

// ===== dv/fdr_reflectance_checker.sv =====
// Checker that predicts the Fresnel reflectance of each request and compares responses.
`timescale 1ns / 100ps
`default_nettype none
module fdr_reflectance_checker import fdr_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  fdr_in_if req,
  fdr_out_if rsp,
  output int errors,
  output int pending
);

  typedef struct packed {
    logic [REFL_W-1:0] reflectance;
    logic total_reflection;
  } refl_result_t;

  refl_result_t refl_queue[$];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] amplitude_q31(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] d;
    d = (x >= y) ? x - y : y - x;
    if (x + y == 0) return 64'd1 << 31;
    return (d << 31) / (x + y);
  endfunction

  function automatic refl_result_t fresnel_predict(input logic signed [COS_W-1:0] cos_in,
                                                   input logic [ETA_W-1:0] eta_in,
                                                   input logic [ETA_W-1:0] eta_out);
    refl_result_t r;
    int cs;
    logic [63:0] ei, et, c, s2, lhs, rhs, ct, q1, q2, acc, one;
    one = 64'd1 << FRAC_BITS_DEF;
    cs = int'(cos_in);
    ei = 64'(eta_in);
    et = 64'(eta_out);
    if (cs > 16384) cs = 16384;
    if (cs < -16384) cs = -16384;
    if (cs < 0) begin
      ei = 64'(eta_out);
      et = 64'(eta_in);
      cs = -cs;
    end
    c = 64'(cs);
    s2 = (64'd1 << 28) - c * c;
    lhs = ei * ei * s2;
    rhs = (et * et) << 28;
    if (lhs >= rhs) begin
      r.reflectance = one[REFL_W-1:0];
      r.total_reflection = 1'b1;
      return r;
    end
    ct = isqrt64((rhs - lhs) / (et * et));
    q1 = amplitude_q31(et * c, ei * ct);
    q2 = amplitude_q31(ei * c, et * ct);
    acc = q1 * q1 + q2 * q2 + (64'd1 << (62 - FRAC_BITS_DEF));
    acc = acc >> (63 - FRAC_BITS_DEF);
    if (acc > one) acc = one;
    r.reflectance = acc[REFL_W-1:0];
    r.total_reflection = 1'b0;
    return r;
  endfunction

  assign pending = refl_queue.size();

  always @(posedge clk) begin
    refl_result_t want;
    if (rst) begin
      errors <= errors;
    end else begin
      if (req.valid && req.ready) begin
        refl_queue.push_back(fresnel_predict(req.cos_incident, req.eta_incident,
                                             req.eta_transmitted));
      end
      if (rsp.valid && rsp.ready) begin
        if (refl_queue.size() == 0) begin
          $display("%0t: unexpected response transaction refl=%0d tir=%0d", $time,
                   rsp.reflectance, rsp.total_reflection);
          errors <= errors + 1;
        end else begin
          want = refl_queue.pop_front();
          if (want.reflectance !== rsp.reflectance ||
              want.total_reflection !== rsp.total_reflection) begin
            $display("%0t: mismatch expected refl=%0d tir=%0d actual refl=%0d tir=%0d",
                     $time, want.reflectance, want.total_reflection,
                     rsp.reflectance, rsp.total_reflection);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  initial errors = 0;

endmodule
`default_nettype wire

// ===== dv/tb_fresnel_dielectric_reflectance.sv =====
// Testbench top: drives Fresnel reflectance requests and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_fresnel_dielectric_reflectance;
  import fdr_pkg::*;

  logic clk;
  logic rst;
  int errors;
  int pending;
  int tx_idle;
  int rx_idle;
  longint cycles;

  fdr_in_if req();
  fdr_out_if rsp();

  fresnel_dielectric_reflectance u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  fdr_reflectance_checker u_checker (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .errors(errors),
    .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    rsp.ready <= ($urandom_range(99) >= rx_idle);
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [COS_W-1:0] c, input logic [ETA_W-1:0] ei,
                             input logic [ETA_W-1:0] et);
    logic r;
    if ($urandom_range(99) < tx_idle) begin
      req.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    req.valid <= 1'b1;
    req.cos_incident <= c;
    req.eta_incident <= ei;
    req.eta_transmitted <= et;
    forever begin
      @(negedge clk);
      r = req.ready;
      @(posedge clk);
      if (r) break;
    end
  endtask

  task automatic drain_results();
    req.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random();
    logic [ETA_W-1:0] ei, et;
    logic signed [COS_W-1:0] c;
    if ($urandom_range(9) < 7) begin
      ei = ETA_W'($urandom_range(12288, 4096));
      et = ETA_W'($urandom_range(12288, 4096));
      c = COS_W'($urandom_range(32768) - 16384);
    end else begin
      ei = ETA_W'($urandom_range(65535, 1));
      et = ETA_W'($urandom_range(65535, 1));
      c = COS_W'($urandom);
    end
    send_sample(c, ei, et);
  endtask

  initial begin
    logic signed [COS_W-1:0] cos_set[7];
    cycles = 0;
    rst = 1'b1;
    tx_idle = 8;
    rx_idle = 55;
    req.valid = 1'b0;
    req.cos_incident = '0;
    req.eta_incident = 16'd4096;
    req.eta_transmitted = 16'd4096;
    rsp.ready = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    cos_set = '{-16'sd32768, 16'sd32767, 16'sd16384, -16'sd16384, 16'sd0, 16'sd1, -16'sd1};
    foreach (cos_set[i]) send_sample(cos_set[i], 16'd4096, 16'd6144);
    send_sample(16'sd8192, 16'd6144, 16'd4096);
    send_sample(-16'sd8192, 16'd6144, 16'd4096);
    send_sample(16'sd0, 16'd6144, 16'd4096);
    send_sample(16'sd16384, 16'd4096, 16'd4096);
    send_sample(16'sd3000, 16'd4096, 16'd4096);
    send_sample(16'sd16384, 16'd1, 16'd65535);
    send_sample(16'sd16384, 16'd65535, 16'd1);
    send_sample(-16'sd20000, 16'd1, 16'd65535);
    send_sample(16'sd100, 16'd65535, 16'd65535);
    send_sample(16'sd1, 16'd65535, 16'd1);
    drain_results();
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 8 : (phase == 1) ? 55 : 0;
      rx_idle = (phase == 0) ? 55 : (phase == 1) ? 8 : 0;
      for (int n = 0; n < 510; n++) begin
        send_random();
        if (phase == 1 && n == 250) drain_results();
      end
    end
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
